### hw/rtl/kre_pkg.sv
package kre_pkg;

    localparam int INPUT_SLOTS = 6;
    localparam int MAX_EVENTS  = 18;
    localparam int CNT_W       = $clog2(MAX_EVENTS);

    localparam int MOD_LCTRL_BIT = 0;
    localparam int MOD_LALT_BIT  = 2;
    localparam int MOD_RCTRL_BIT = 4;
    localparam int MOD_RALT_BIT  = 6;

    localparam logic [7:0] CTRL_KEY    = 8'hE0;
    localparam logic [7:0] MODE_KEY    = 8'h4D;
    localparam logic [7:0] MACRO_KEY_A = 8'h3E;
    localparam logic [7:0] MACRO_KEY_B = 8'h3F;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_MODE    = 2'd2;
    localparam logic [1:0] KIND_MACRO   = 2'd3;

    localparam logic CFG_LEFT_ALT  = 1'b0;
    localparam logic CFG_RIGHT_ALT = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key;
        logic [7:0] modifier;
    } event_t;

endpackage

### hw/rtl/keyboard_report_to_key_events.sv
// Boot-keyboard report differ. Each report (modifier byte and six key slots) is compared
// with the previous one and turned into key events: alt and ctrl edges, presses of new
// keys with the current modifier, releases of vanished keys with the old modifier, then
// mode and macro requests; tlast marks the final event of a report and a report that
// changes nothing gives no event. A report passes an input register into an event buffer,
// which drains through the output register at one event per cycle unless the output
// stalls. A report gives at most 18 events, and the next report enters the buffer in the
// cycle its last event leaves. The first event reaches the output register after the input
// register and the event buffer. The user must write alt keycodes only while the block is
// idle; the block does not enforce this. Index 0 is left alt, 1 right.
module keyboard_report_to_key_events #(
    parameter int KEY_SLOTS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // modifier_bits, slot_zero, slot_one, slot_two, slot_three, slot_four, slot_five
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_key, event_modifier
    output logic [15:0] m_tdata,
    // event_kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import kre_pkg::*;

    localparam int NUM_EV = 2 * KEY_SLOTS + 6;
    localparam int IDX_W  = $clog2(NUM_EV);

    logic [7:0]  left_alt_reg, right_alt_reg;
    logic        in_valid_reg;
    logic [7:0]  in_mod_reg;
    logic [7:0]  in_slot_reg [INPUT_SLOTS];
    logic [7:0]  cur_slot [KEY_SLOTS];
    logic [7:0]  prev_mod_reg;
    logic [7:0]  prev_slot_reg [KEY_SLOTS];

    event_t      diff_ev [NUM_EV];
    logic [NUM_EV-1:0] diff_valid;

    event_t      ent_reg [NUM_EV];
    logic [NUM_EV-1:0] pend_reg, pend_next, rest;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  pop_idx;
    logic        found;
    logic        pop_fire, pop_last, buf_free, buf_load, s_fire;

    logic        out_valid_reg, out_valid_next;
    event_t      out_ev_reg;
    logic        out_last_reg;

    genvar g;
    generate
        for (g = 0; g < KEY_SLOTS; g++)
        begin : g_cur
            if (g < INPUT_SLOTS)
            begin : g_in
                assign cur_slot[g] = in_slot_reg[g];
            end
            else
            begin : g_empty
                assign cur_slot[g] = 8'd0;
            end
        end
    endgenerate

    kre_diff #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_diff (
        .cur_mod      (in_mod_reg),
        .cur_slot     (cur_slot),
        .prev_mod     (prev_mod_reg),
        .prev_slot    (prev_slot_reg),
        .left_alt_key (left_alt_reg),
        .right_alt_key(right_alt_reg),
        .ev           (diff_ev),
        .ev_valid     (diff_valid)
    );

    // pick the lowest pending event
    always_comb
    begin
        pop_idx = '0;
        found   = 1'b0;
        for (int k = 0; k < NUM_EV; k++)
        begin
            if (pend_reg[k] && !found)
            begin
                pop_idx = IDX_W'(k);
                found   = 1'b1;
            end
        end
    end

    assign rest     = pend_reg & ~(NUM_EV'(1) << pop_idx);
    assign pop_last = (rest == '0) || (cnt_reg == CNT_W'(MAX_EVENTS - 1));
    assign pop_fire = found && (!out_valid_reg || m_tready);
    assign buf_free = (pend_reg == '0) || (pop_fire && pop_last);
    assign buf_load = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        if (pop_fire)
        begin
            pend_next = pop_last ? '0 : rest;
            cnt_next  = pop_last ? '0 : cnt_reg + CNT_W'(1);
        end
        if (buf_load)
        begin
            pend_next = diff_valid;
            cnt_next  = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_alt_reg  <= 8'd0;
            right_alt_reg <= 8'd0;
            in_valid_reg  <= 1'b0;
            prev_mod_reg  <= 8'd0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_slot_reg[i] <= 8'd0;
            end
            pend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEFT_ALT:  left_alt_reg  <= cfg_data;
                    CFG_RIGHT_ALT: right_alt_reg <= cfg_data;
                    default:       left_alt_reg  <= left_alt_reg;
                endcase
            end
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (buf_load)
            begin
                in_valid_reg <= 1'b0;
            end
            // advance the stored report
            if (buf_load)
            begin
                prev_mod_reg <= in_mod_reg;
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    prev_slot_reg[i] <= cur_slot[i];
                end
            end
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_mod_reg <= s_tdata[7:0];
            for (int i = 0; i < INPUT_SLOTS; i++)
            begin
                in_slot_reg[i] <= s_tdata[8 + 8 * i +: 8];
            end
        end
        if (buf_load)
        begin
            for (int k = 0; k < NUM_EV; k++)
            begin
                ent_reg[k] <= diff_ev[k];
            end
        end
        if (pop_fire)
        begin
            out_ev_reg   <= ent_reg[pop_idx];
            out_last_reg <= pop_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ev_reg.modifier, out_ev_reg.key};
    assign m_tuser  = out_ev_reg.kind;
    assign m_tlast  = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(MAX_EVENTS))
        else $error("event count past limit");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && pop_last && !buf_load |=> pend_reg == '0)
        else $error("events left after final event");

    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> in_valid_reg)
        else $error("accepted report lost");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire |=> m_tvalid)
        else $error("popped event not presented");

endmodule

### hw/rtl/kre_diff.sv
module kre_diff #(
    parameter int KEY_SLOTS = 6,
    localparam int NUM_EV = 2 * KEY_SLOTS + 6
) (
    input  logic [7:0]      cur_mod,
    input  logic [7:0]      cur_slot [KEY_SLOTS],
    input  logic [7:0]      prev_mod,
    input  logic [7:0]      prev_slot [KEY_SLOTS],
    input  logic [7:0]      left_alt_key,
    input  logic [7:0]      right_alt_key,
    output kre_pkg::event_t ev [NUM_EV],
    output logic [NUM_EV-1:0] ev_valid
);
    import kre_pkg::*;

    localparam int PRESS_BASE   = 3;
    localparam int RELEASE_BASE = 3 + KEY_SLOTS;
    localparam int SPECIAL_BASE = 3 + 2 * KEY_SLOTS;

    logic [KEY_SLOTS-1:0] new_key;
    logic [KEY_SLOTS-1:0] gone_key;
    logic mode_now, mode_prev, maca_now, maca_prev, macb_now, macb_prev;
    logic lalt_now, lalt_prev, ralt_now, ralt_prev, ctrl_now, ctrl_prev;

    always_comb
    begin
        mode_now  = 1'b0;
        mode_prev = 1'b0;
        maca_now  = 1'b0;
        maca_prev = 1'b0;
        macb_now  = 1'b0;
        macb_prev = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            new_key[i]  = (cur_slot[i] != 8'd0);
            gone_key[i] = (prev_slot[i] != 8'd0);
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (prev_slot[j] == cur_slot[i])
                begin
                    new_key[i] = 1'b0;
                end
                if (cur_slot[j] == prev_slot[i])
                begin
                    gone_key[i] = 1'b0;
                end
            end
            mode_now  = mode_now  | (cur_slot[i]  == MODE_KEY);
            mode_prev = mode_prev | (prev_slot[i] == MODE_KEY);
            maca_now  = maca_now  | (cur_slot[i]  == MACRO_KEY_A);
            maca_prev = maca_prev | (prev_slot[i] == MACRO_KEY_A);
            macb_now  = macb_now  | (cur_slot[i]  == MACRO_KEY_B);
            macb_prev = macb_prev | (prev_slot[i] == MACRO_KEY_B);
        end
    end

    assign lalt_now  = cur_mod[MOD_LALT_BIT];
    assign lalt_prev = prev_mod[MOD_LALT_BIT];
    assign ralt_now  = cur_mod[MOD_RALT_BIT];
    assign ralt_prev = prev_mod[MOD_RALT_BIT];
    assign ctrl_now  = cur_mod[MOD_LCTRL_BIT] | cur_mod[MOD_RCTRL_BIT];
    assign ctrl_prev = prev_mod[MOD_LCTRL_BIT] | prev_mod[MOD_RCTRL_BIT];

    always_comb
    begin
        ev[0].kind     = lalt_now ? KIND_PRESS : KIND_RELEASE;
        ev[0].key      = left_alt_key;
        ev[0].modifier = 8'd0;
        ev_valid[0]    = lalt_now ^ lalt_prev;

        ev[1].kind     = ralt_now ? KIND_PRESS : KIND_RELEASE;
        ev[1].key      = right_alt_key;
        ev[1].modifier = 8'd0;
        ev_valid[1]    = ralt_now ^ ralt_prev;

        ev[2].kind     = ctrl_now ? KIND_PRESS : KIND_RELEASE;
        ev[2].key      = CTRL_KEY;
        ev[2].modifier = 8'd0;
        ev_valid[2]    = ctrl_now ^ ctrl_prev;

        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            ev[PRESS_BASE + i].kind         = KIND_PRESS;
            ev[PRESS_BASE + i].key          = cur_slot[i];
            ev[PRESS_BASE + i].modifier     = cur_mod;
            ev_valid[PRESS_BASE + i]        = new_key[i];
            ev[RELEASE_BASE + i].kind       = KIND_RELEASE;
            ev[RELEASE_BASE + i].key        = prev_slot[i];
            ev[RELEASE_BASE + i].modifier   = prev_mod;
            ev_valid[RELEASE_BASE + i]      = gone_key[i];
        end

        ev[SPECIAL_BASE].kind         = KIND_MODE;
        ev[SPECIAL_BASE].key          = MODE_KEY;
        ev[SPECIAL_BASE].modifier     = 8'd0;
        ev_valid[SPECIAL_BASE]        = mode_now & ~mode_prev;

        ev[SPECIAL_BASE + 1].kind     = KIND_MACRO;
        ev[SPECIAL_BASE + 1].key      = MACRO_KEY_A;
        ev[SPECIAL_BASE + 1].modifier = 8'd0;
        ev_valid[SPECIAL_BASE + 1]    = maca_now & ~maca_prev;

        ev[SPECIAL_BASE + 2].kind     = KIND_MACRO;
        ev[SPECIAL_BASE + 2].key      = MACRO_KEY_B;
        ev[SPECIAL_BASE + 2].modifier = 8'd0;
        ev_valid[SPECIAL_BASE + 2]    = macb_now & ~macb_prev;
    end

endmodule
